// File: rtl/mstk_pkg.sv
// package: sizes, record types and controller states of the kruskal core
package mstk_pkg;

    localparam int MAX_EDGES    = 64;
    localparam int MAX_VERTICES = 32;
    localparam int WEIGHT_BITS  = 16;
    localparam int VTX_BITS     = 6;
    localparam int SUM_BITS     = 21;
    localparam int EIDX_BITS    = $clog2(MAX_EDGES);
    localparam int ECNT_BITS    = $clog2(MAX_EDGES + 1);
    localparam int PIDX_BITS    = $clog2(MAX_VERTICES + 1);
    localparam int GUARD_BITS   = $clog2(MAX_VERTICES + 2);

    typedef struct packed {
        logic signed [WEIGHT_BITS-1:0] wt;
        logic [VTX_BITS-1:0]           b;
        logic [VTX_BITS-1:0]           a;
    } edge_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_INIT,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_FIND_U,
        ST_FIND_V,
        ST_JOIN,
        ST_EMIT,
        ST_EMPTY
    } state_t;

endpackage

// File: rtl/minimum_spanning_tree_kruskal_core.sv
// top level: edge store, insertion sort and union-find over block memories
// operation: edges load at one word per cycle; an insertion sort then orders them by weight,
// the parent table is rebuilt, and each edge is read and range checked; when both ends are
// in range its two roots are found by following parent hops, and joined if they differ
// throughput: one graph at a time; a tree word is held until the next is found, and input is
// taken again once the final word of the run is registered
// reset: control, counters and flags clear at once; memories hold no reset value
module minimum_spanning_tree_kruskal_core
    import mstk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // edge_from[5:0], edge_to[11:6], edge_weight[27:12]
    input  logic        s_axis_tlast,   // last_edge
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // tree_from, tree_to, tree_weight, running_total
    output logic        m_axis_tlast,   // last_result
    output logic [1:0]  m_axis_tuser    // tree_valid, edges_dropped
);

    state_t state_reg, state_next;
    logic [5:0] vcount_reg;
    logic [ECNT_BITS-1:0] total_reg;
    logic ovf_reg;
    logic [ECNT_BITS-1:0] i_reg;
    logic [EIDX_BITS-1:0] j_reg;
    edge_t key_reg, cur_reg, rd_q;
    logic [PIDX_BITS-1:0] p_reg, ru_reg, cnode_reg, par_q;
    logic [GUARD_BITS-1:0] guard_reg;
    logic signed [SUM_BITS-1:0] sum_reg;
    logic any_reg;
    logic [5:0] n_lim;

    // memories
    edge_t edge_mem [MAX_EDGES];
    logic [PIDX_BITS-1:0] par_mem [MAX_VERTICES+1];

    // memory controls
    logic e_we;
    logic [EIDX_BITS-1:0] e_waddr, e_raddr;
    edge_t e_wdata;
    logic p_we;
    logic [PIDX_BITS-1:0] p_addr, p_wdata;

    // output register and the tree word held back until its last flag is known
    logic ov_reg;
    logic [55:0] od_reg;
    logic ol_reg;
    logic [1:0] ou_reg;
    logic [55:0] pend_reg;

    assign n_lim = (vcount_reg > 6'(MAX_VERTICES)) ? 6'(MAX_VERTICES) : vcount_reg;
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tuser  = ou_reg;

    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;
    logic out_free;
    assign out_free = !ov_reg || m_axis_tready;
    logic out_load;
    assign out_load = out_free && ((state_reg == ST_EMIT && any_reg) || state_reg == ST_EMPTY);

    edge_t in_edge;
    assign in_edge = '{wt: s_axis_tdata[27:12], b: s_axis_tdata[11:6], a: s_axis_tdata[5:0]};

    // endpoint range check on the edge just read, and root test
    logic cur_ok;
    assign cur_ok = (rd_q.a >= 6'd1) && (rd_q.a <= n_lim)
                 && (rd_q.b >= 6'd1) && (rd_q.b <= n_lim);
    logic at_root;
    assign at_root = (par_q == cnode_reg) || (guard_reg > GUARD_BITS'(MAX_VERTICES));

    // edge memory port, plus the sort key read
    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[e_waddr] <= e_wdata;
        end
        rd_q <= edge_mem[e_raddr];
        if (state_reg == ST_SORT_RD)
        begin
            key_reg <= edge_mem[i_reg[EIDX_BITS-1:0]];
        end
    end

    // parent memory port, read first
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            par_mem[p_addr] <= p_wdata;
        end
        par_q <= par_mem[p_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:     if (acc && s_axis_tlast) state_next = ST_SORT_RD;
            ST_SORT_RD:
            begin
                if (i_reg >= total_reg) state_next = ST_INIT;
                else state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                if (j_reg == '0 || !($signed(rd_q.wt) > $signed(key_reg.wt)))
                    state_next = ST_SORT_RD;
            end
            ST_INIT:     if (p_reg == PIDX_BITS'(MAX_VERTICES)) state_next = ST_EDGE_RD;
            ST_EDGE_RD:
            begin
                if (i_reg >= total_reg) state_next = ST_EMPTY;
                else state_next = ST_EDGE_CHK;
            end
            ST_EDGE_CHK: state_next = cur_ok ? ST_FIND_U : ST_EDGE_RD;
            ST_FIND_U:   if (at_root) state_next = ST_FIND_V;
            ST_FIND_V:
            begin
                if (at_root) state_next = (cnode_reg == ru_reg) ? ST_EDGE_RD : ST_JOIN;
            end
            ST_JOIN:     state_next = ST_EMIT;
            ST_EMIT:     if (out_free || !any_reg) state_next = ST_EDGE_RD;
            ST_EMPTY:    if (out_free) state_next = ST_LOAD;
            default:     state_next = ST_LOAD;
        endcase
    end

    // memory addresses and write strobes
    always_comb
    begin
        e_we = 1'b0;
        e_waddr = total_reg[EIDX_BITS-1:0];
        e_wdata = in_edge;
        e_raddr = i_reg[EIDX_BITS-1:0];
        p_we = 1'b0;
        p_addr = cnode_reg;
        p_wdata = p_reg;
        case (state_reg)
            ST_LOAD:
            begin
                e_we = acc && (total_reg < ECNT_BITS'(MAX_EDGES));
            end
            ST_SORT_RD:  e_raddr = i_reg[EIDX_BITS-1:0] - 1'b1;
            ST_SORT_CMP:
            begin
                e_we = 1'b1;
                e_waddr = j_reg;
                if (j_reg != '0 && $signed(rd_q.wt) > $signed(key_reg.wt))
                begin
                    e_wdata = rd_q;
                    e_raddr = j_reg - 2'd2;
                end
                else
                begin
                    e_wdata = key_reg;
                end
            end
            ST_INIT:
            begin
                p_we = 1'b1;
                p_addr = p_reg;
            end
            ST_EDGE_CHK: p_addr = PIDX_BITS'(rd_q.a);
            ST_FIND_U, ST_FIND_V: p_addr = at_root ? PIDX_BITS'(cur_reg.b) : par_q;
            ST_JOIN:
            begin
                p_we = 1'b1;
                p_addr = cnode_reg;
                p_wdata = ru_reg;
            end
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            vcount_reg <= 6'd32;
            total_reg <= '0;
            ovf_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            p_reg <= '0;
            ru_reg <= '0;
            cnode_reg <= '0;
            guard_reg <= '0;
            sum_reg <= '0;
            any_reg <= 1'b0;
            ov_reg <= 1'b0;
            ol_reg <= 1'b0;
            ou_reg <= '0;
            od_reg <= '0;
            pend_reg <= '0;
            cur_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) vcount_reg <= cfg_data;
            if (out_load) ov_reg <= 1'b1;
            else if (m_axis_tready) ov_reg <= 1'b0;
            case (state_reg)
                ST_LOAD:
                begin
                    if (acc)
                    begin
                        if (total_reg < ECNT_BITS'(MAX_EDGES)) total_reg <= total_reg + 1'b1;
                        else ovf_reg <= 1'b1;
                        i_reg <= ECNT_BITS'(1);
                    end
                end
                ST_SORT_RD:
                begin
                    if (i_reg < total_reg)
                    begin
                        j_reg <= i_reg[EIDX_BITS-1:0];
                    end
                    p_reg <= '0;
                end
                ST_SORT_CMP:
                begin
                    if (j_reg != '0 && $signed(rd_q.wt) > $signed(key_reg.wt))
                        j_reg <= j_reg - 1'b1;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                ST_INIT:
                begin
                    p_reg <= p_reg + 1'b1;
                    i_reg <= '0;
                    sum_reg <= '0;
                    any_reg <= 1'b0;
                end
                ST_EDGE_RD:
                begin
                    i_reg <= i_reg + 1'b1;
                end
                ST_EDGE_CHK:
                begin
                    cur_reg <= rd_q;
                    cnode_reg <= PIDX_BITS'(rd_q.a);
                    guard_reg <= '0;
                end
                ST_FIND_U, ST_FIND_V:
                begin
                    if (at_root)
                    begin
                        if (state_reg == ST_FIND_U) ru_reg <= cnode_reg;
                        else cnode_reg <= cnode_reg;
                        if (state_reg == ST_FIND_U) cnode_reg <= PIDX_BITS'(cur_reg.b);
                        guard_reg <= '0;
                    end
                    else
                    begin
                        cnode_reg <= par_q;
                        guard_reg <= guard_reg + 1'b1;
                    end
                end
                ST_JOIN:
                begin
                    sum_reg <= sum_reg + SUM_BITS'(cur_reg.wt);
                    p_reg <= '0;
                end
                // send the held word on, then hold the new one
                ST_EMIT:
                begin
                    if (out_free || !any_reg)
                    begin
                        if (any_reg)
                        begin
                            od_reg <= pend_reg;
                            ou_reg <= {ovf_reg, 1'b1};
                            ol_reg <= 1'b0;
                        end
                        pend_reg <= {7'd0, sum_reg, cur_reg.wt, cur_reg.b, cur_reg.a};
                        any_reg <= 1'b1;
                    end
                end
                // final word of the run: the held edge, or an empty word
                ST_EMPTY:
                begin
                    if (out_free)
                    begin
                        od_reg <= any_reg ? pend_reg : '0;
                        ou_reg <= {ovf_reg, any_reg};
                        ol_reg <= 1'b1;
                        total_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/mstk_checker.sv
// checker: port-level properties of the kruskal core, bound to the top level
module mstk_checker
    import mstk_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an empty result carries zero data
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("empty result with data");

    // no input taken while a run still has words to give
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready during run");

endmodule

bind minimum_spanning_tree_kruskal_core mstk_checker u_chk (.*);

// File: tb/tb.sv
// testbench for the kruskal minimum spanning tree core
`timescale 1ns / 100ps

class mst_scoreboard;
    typedef struct {
        logic [5:0]         a;
        logic [5:0]         b;
        logic signed [15:0] wt;
    } graph_edge_t;

    typedef struct {
        logic [5:0]  from_v;
        logic [5:0]  to_v;
        logic [15:0] wt;
        logic [20:0] total;
        logic        valid;
        logic        last;
        logic        dropped;
    } tree_word_t;

    graph_edge_t edges[$];
    tree_word_t  tree_q[$];
    bit          overflow;
    int          vertices;
    int          errors;
    int          results_seen;
    int          graphs;

    function new();
        vertices = 32;
    endfunction

    // kruskal over the stored graph once the closing edge arrives
    function void note_edge(logic [5:0] a, logic [5:0] b, logic [15:0] wt, logic closing);
        graph_edge_t e, sorted[$];
        int parent[33];
        int n, ru, rv, cnt, j;
        logic signed [20:0] sum;
        tree_word_t r;
        e.a = a;
        e.b = b;
        e.wt = wt;
        if (edges.size() < 64)
            edges.push_back(e);
        else
            overflow = 1;
        if (!closing)
            return;
        graphs++;
        // stable insertion sort by weight
        foreach (edges[i])
        begin
            j = sorted.size();
            while (j > 0 && sorted[j-1].wt > edges[i].wt)
                j--;
            sorted.insert(j, edges[i]);
        end
        n = (vertices > 32) ? 32 : vertices;
        for (int k = 0; k <= 32; k++)
            parent[k] = k;
        sum = 0;
        cnt = 0;
        foreach (sorted[i])
        begin
            if (sorted[i].a < 1 || sorted[i].a > n || sorted[i].b < 1 || sorted[i].b > n)
                continue;
            ru = sorted[i].a;
            while (parent[ru] != ru)
                ru = parent[ru];
            rv = sorted[i].b;
            while (parent[rv] != rv)
                rv = parent[rv];
            if (ru != rv)
            begin
                parent[rv] = ru;
                sum += 21'(sorted[i].wt);
                r.from_v = sorted[i].a;
                r.to_v = sorted[i].b;
                r.wt = sorted[i].wt;
                r.total = sum;
                r.valid = 1;
                r.last = 0;
                r.dropped = overflow;
                tree_q.push_back(r);
                cnt++;
            end
        end
        if (cnt == 0)
        begin
            r = '{0, 0, 0, 0, 0, 1, overflow};
            tree_q.push_back(r);
        end
        else
            tree_q[tree_q.size()-1].last = 1;
        edges.delete();
        overflow = 0;
    endfunction

    function void check_word(logic [55:0] d, logic last, logic [1:0] user);
        tree_word_t x;
        results_seen++;
        if (tree_q.size() == 0)
        begin
            $error("unexpected result word %h", d);
            errors++;
            return;
        end
        x = tree_q.pop_front();
        if (d[5:0] !== x.from_v)
        begin
            $error("tree_from expected %0d actual %0d", x.from_v, d[5:0]);
            errors++;
        end
        if (d[11:6] !== x.to_v)
        begin
            $error("tree_to expected %0d actual %0d", x.to_v, d[11:6]);
            errors++;
        end
        if (d[27:12] !== x.wt)
        begin
            $error("tree_weight expected %h actual %h", x.wt, d[27:12]);
            errors++;
        end
        if (d[48:28] !== x.total)
        begin
            $error("running_total expected %h actual %h", x.total, d[48:28]);
            errors++;
        end
        if (user[0] !== x.valid)
        begin
            $error("tree_valid expected %0d actual %0d", x.valid, user[0]);
            errors++;
        end
        if (last !== x.last)
        begin
            $error("last_result expected %0d actual %0d", x.last, last);
            errors++;
        end
        if (user[1] !== x.dropped)
        begin
            $error("edges_dropped expected %0d actual %0d", x.dropped, user[1]);
            errors++;
        end
    endfunction
endclass

module tb;
    import mstk_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [5:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    mst_scoreboard sb;
    bit calm;
    int edges_sent;

    minimum_spanning_tree_kruskal_core DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver with random stalls
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        m_axis_tready <= calm || ($urandom_range(99) >= 38);
    end

    // send one edge, idling at random first
    task automatic send_edge(logic [5:0] a, logic [5:0] b, logic [15:0] wt, logic closing);
        while (!calm && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, wt, b, a};
        s_axis_tlast <= closing;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_edge(a, b, wt, closing);
        edges_sent++;
        if (closing)
            s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.tree_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_vertices(logic [5:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.vertices = v;
    endtask

    function automatic logic [5:0] pick_vertex(int n);
        if ($urandom_range(19) == 0)
            return 6'($urandom_range(63));
        return 6'($urandom_range(n < 1 ? 1 : n, 1));
    endfunction

    // random graph, mostly in range
    task automatic random_graph(int n, int count);
        logic [15:0] wt;
        for (int i = 0; i < count; i++)
        begin
            wt = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(15));
            send_edge(pick_vertex(n), pick_vertex(n), wt, i == count - 1);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        calm = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, ties, self loop, out of range, lone closing edge
        send_edge(1, 32, 16'h8000, 0);
        send_edge(32, 1, 16'h7fff, 0);
        send_edge(5, 5, 16'h0000, 0);
        send_edge(0, 3, 16'h0001, 0);
        send_edge(63, 2, 16'h0001, 0);
        send_edge(2, 3, 16'h0005, 0);
        send_edge(3, 4, 16'h0005, 0);
        send_edge(2, 4, 16'h0005, 1);
        drain();
        send_edge(7, 7, 16'hffff, 1);
        drain();
        set_vertices(1);
        send_edge(1, 1, 16'h0003, 0);
        send_edge(1, 2, 16'h0003, 1);
        drain();
        set_vertices(0);
        send_edge(1, 2, 16'h0003, 1);
        drain();
        set_vertices(63);
        send_edge(40, 2, 16'h0001, 0);
        send_edge(31, 32, 16'h0002, 1);
        drain();

        // store overflow: one graph sent as 66 words, two more than the store holds
        set_vertices(32);
        random_graph(32, 66);
        drain();

        // random graphs under varied vertex counts
        while (edges_sent < 420)
        begin
            calm = (edges_sent > 250 && edges_sent < 310);
            set_vertices(6'($urandom_range(1) ? $urandom_range(32, 1) : $urandom_range(8, 2)));
            random_graph(sb.vertices, $urandom_range(24, 1));
            drain();
        end
        set_vertices(32);

        $display("%0d edges sent over %0d graphs, %0d result words checked",
                 edges_sent, sb.graphs, sb.results_seen);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // overall watchdog
    initial
    begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end
endmodule

// File: minimum_spanning_tree_kruskal_core.f
rtl/mstk_pkg.sv
rtl/minimum_spanning_tree_kruskal_core.sv
rtl/mstk_checker.sv
tb/tb.sv
